/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* rtl/tibp_pkg.sv */
// ----------------------------------------------------------------------------
// tibp_pkg
// Types and constants of the transaction input byte parser.
// ----------------------------------------------------------------------------
package tibp_pkg;

  // Number of previous-hash bytes per input
  localparam int HASH_BYTES = 32;

  // Parser phases
  localparam logic [3:0] PH_VERSION    = 4'd0;
  localparam logic [3:0] PH_COUNT      = 4'd1;
  localparam logic [3:0] PH_HASH       = 4'd2;
  localparam logic [3:0] PH_INDEX      = 4'd3;
  localparam logic [3:0] PH_SCRIPT_LEN = 4'd4;
  localparam logic [3:0] PH_COINBASE   = 4'd5;
  localparam logic [3:0] PH_OPCODE     = 4'd6;
  localparam logic [3:0] PH_PUSH       = 4'd7;
  localparam logic [3:0] PH_SEQUENCE   = 4'd8;

  // Result kinds
  localparam logic [3:0] KIND_VERSION    = 4'd0;
  localparam logic [3:0] KIND_COUNT      = 4'd1;
  localparam logic [3:0] KIND_HASH       = 4'd2;
  localparam logic [3:0] KIND_INDEX      = 4'd3;
  localparam logic [3:0] KIND_SCRIPT_LEN = 4'd4;
  localparam logic [3:0] KIND_COINBASE   = 4'd5;
  localparam logic [3:0] KIND_SIGNATURE  = 4'd6;
  localparam logic [3:0] KIND_PUBKEY     = 4'd7;
  localparam logic [3:0] KIND_SEQUENCE   = 4'd8;

  // Varint prefixes and push opcode range
  localparam logic [7:0] VARINT_16    = 8'hFD;
  localparam logic [7:0] VARINT_32    = 8'hFE;
  localparam logic [7:0] PUSH_MIN     = 8'h01;
  localparam logic [7:0] PUSH_MAX     = 8'h4B;
  localparam logic [31:0] COINBASE_INDEX = 32'hFFFF_FFFF;

  // Parser state
  typedef struct packed {
    logic [3:0]  phase;
    logic [63:0] counter;
    logic [63:0] acc;
    logic [3:0]  varint_left;
    logic        hash_zero;
    logic        index_ones;
    logic [6:0]  push_left;
    logic        push_num;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_VERSION,
    counter:     64'd0,
    acc:         64'd0,
    varint_left: 4'd0,
    hash_zero:   1'b1,
    index_ones:  1'b0,
    push_left:   7'd0,
    push_num:    1'b0
  };

  // Result item
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [7:0]  pos;
    logic        coinbase;
    logic        last;
  } result_t;

endpackage

/* rtl/tibp_byte_if.sv */
// ----------------------------------------------------------------------------
// tibp_byte_if
// Raw transaction byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tibp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

/* rtl/tibp_field_if.sv */
// ----------------------------------------------------------------------------
// tibp_field_if
// Decoded field channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tibp_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [63:0] field_value;
  logic [7:0]  byte_position;
  logic        is_coinbase;
  logic        last_of_transaction;

  modport source (output valid, output field_kind, output field_value,
                  output byte_position, output is_coinbase,
                  output last_of_transaction, input ready);
  modport sink   (input valid, input field_kind, input field_value,
                  input byte_position, input is_coinbase,
                  input last_of_transaction, output ready);
endinterface

/* rtl/transaction_input_byte_parser_core.sv */
// A result appears on the field channel in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the field channel takes results; the parser state and
// the result register close in one pass of byte decode logic, so the next byte can follow at once.
// A byte is taken while a result waits, as long as that result leaves in the same cycle.
// Reset (rst, synchronous) returns the parser to the version field and drops any result.
// ----------------------------------------------------------------------------
// transaction_input_byte_parser_core
// Byte-serial parser for the first input of a serialized transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transaction_input_byte_parser_core (
  input logic         clk,
  input logic         rst,
  tibp_byte_if.sink   byte_ch,
  tibp_field_if.source field_ch
);

  tibp_pkg::state_t  state;
  tibp_pkg::state_t  state_next;
  tibp_pkg::result_t result;
  tibp_pkg::result_t result_next;
  logic              result_valid;
  logic              produce;
  logic              take;
  logic              in_ready;

  // Accept a byte when the result register is free or draining
  assign in_ready      = !result_valid || field_ch.ready;
  assign byte_ch.ready = in_ready;
  assign take          = byte_ch.valid && in_ready;

  tibp_decode decode (
    .st        (state),
    .data_byte (byte_ch.data_byte),
    .restart   (byte_ch.restart),
    .nxt       (state_next),
    .res_valid (produce),
    .res       (result_next)
  );

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tibp_pkg::STATE_RESET;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Hold the result until the field channel takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= produce;
    end else if (field_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      result <= result_next;
    end
  end

  assign field_ch.valid               = result_valid;
  assign field_ch.field_kind          = result.kind;
  assign field_ch.field_value         = result.value;
  assign field_ch.byte_position       = result.pos;
  assign field_ch.is_coinbase         = result.coinbase;
  assign field_ch.last_of_transaction = result.last;

  // Hash bytes always give a result in the next cycle
  `ASSERT_CLK(a_hash_result, (take && !byte_ch.restart && state.phase == tibp_pkg::PH_HASH) |=> (result_valid && result.kind == tibp_pkg::KIND_HASH), "hash byte gave no hash result")
  // End of transaction is flagged only on the sequence number
  `ASSERT_NEVER(a_last_kind, result_valid && result.last && result.kind != tibp_pkg::KIND_SEQUENCE, "last flag on a non-sequence result")
  // Coinbase flag only rides on the script length
  `ASSERT_NEVER(a_cb_kind, result_valid && result.coinbase && result.kind != tibp_pkg::KIND_SCRIPT_LEN, "coinbase flag on wrong kind")
  // A push in progress always has bytes left
  `ASSERT_NEVER(a_push_left, state.phase == tibp_pkg::PH_PUSH && state.push_left == 7'd0, "push phase with no bytes left")

endmodule

/* rtl/tibp_decode.sv */
// ----------------------------------------------------------------------------
// tibp_decode
// Single-pass next-state and result logic for one transaction byte.
// ----------------------------------------------------------------------------
module tibp_decode (
  input  tibp_pkg::state_t  st,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output tibp_pkg::state_t  nxt,
  output logic              res_valid,
  output tibp_pkg::result_t res
);

  // Open a new field: clear counter, accumulator and varint tracking
  function automatic tibp_pkg::state_t start_field(tibp_pkg::state_t s, logic [3:0] p);
    tibp_pkg::state_t r;
    r             = s;
    r.phase       = p;
    r.counter     = 64'd0;
    r.acc         = 64'd0;
    r.varint_left = 4'd0;
    return r;
  endfunction

  // Close a push slot: go to the pubkey slot or on to the sequence
  function automatic tibp_pkg::state_t end_push(tibp_pkg::state_t s);
    tibp_pkg::state_t r;
    r           = s;
    r.push_left = 7'd0;
    if (!s.push_num) begin
      r.push_num = 1'b1;
      r          = start_field(r, tibp_pkg::PH_OPCODE);
    end else begin
      r = start_field(r, tibp_pkg::PH_SEQUENCE);
    end
    return r;
  endfunction

  tibp_pkg::state_t cur;
  logic [63:0]      wide_byte;
  logic [63:0]      word_acc;
  logic [63:0]      long_acc;
  logic             var_done;
  logic [63:0]      var_value;
  logic             cb;
  logic [6:0]       left_dec;

  assign wide_byte = {56'd0, data_byte};

  always_comb begin
    // Drop to the reset state on restart or on an undefined phase
    cur = st;
    if (restart || st.phase > tibp_pkg::PH_SEQUENCE) begin
      cur = tibp_pkg::STATE_RESET;
    end

    nxt       = cur;
    res       = '0;
    res_valid = 1'b0;
    var_done  = 1'b0;
    var_value = 64'd0;
    cb        = 1'b0;
    left_dec  = cur.push_left;
    word_acc  = cur.acc | (wide_byte << {cur.counter[1:0], 3'b000});
    long_acc  = cur.acc | (wide_byte << {cur.counter[2:0], 3'b000});

    case (cur.phase)
      // Fixed 4-byte little-endian words
      tibp_pkg::PH_VERSION, tibp_pkg::PH_INDEX, tibp_pkg::PH_SEQUENCE: begin
        nxt.acc     = word_acc;
        nxt.counter = cur.counter + 64'd1;
        if (cur.counter == 64'd3) begin
          res_valid = 1'b1;
          res.value = word_acc;
          if (cur.phase == tibp_pkg::PH_VERSION) begin
            res.kind = tibp_pkg::KIND_VERSION;
            nxt      = start_field(cur, tibp_pkg::PH_COUNT);
          end else if (cur.phase == tibp_pkg::PH_INDEX) begin
            res.kind       = tibp_pkg::KIND_INDEX;
            nxt            = start_field(cur, tibp_pkg::PH_SCRIPT_LEN);
            nxt.index_ones = (word_acc[31:0] == tibp_pkg::COINBASE_INDEX);
          end else begin
            res.kind = tibp_pkg::KIND_SEQUENCE;
            res.last = 1'b1;
            nxt      = tibp_pkg::STATE_RESET;
          end
        end
      end

      // Variable-length integers
      tibp_pkg::PH_COUNT, tibp_pkg::PH_SCRIPT_LEN: begin
        if (cur.varint_left == 4'd0) begin
          if (data_byte < tibp_pkg::VARINT_16) begin
            var_done  = 1'b1;
            var_value = wide_byte;
          end else begin
            nxt.acc     = 64'd0;
            nxt.counter = 64'd0;
            if (data_byte == tibp_pkg::VARINT_16) begin
              nxt.varint_left = 4'd2;
            end else if (data_byte == tibp_pkg::VARINT_32) begin
              nxt.varint_left = 4'd4;
            end else begin
              nxt.varint_left = 4'd8;
            end
          end
        end else begin
          nxt.acc         = long_acc;
          nxt.counter     = cur.counter + 64'd1;
          nxt.varint_left = cur.varint_left - 4'd1;
          var_done        = (cur.varint_left == 4'd1);
          var_value       = long_acc;
        end
        if (var_done) begin
          res_valid = 1'b1;
          res.value = var_value;
          if (cur.phase == tibp_pkg::PH_COUNT) begin
            res.kind      = tibp_pkg::KIND_COUNT;
            nxt           = start_field(cur, tibp_pkg::PH_HASH);
            nxt.hash_zero = 1'b1;
          end else begin
            cb           = cur.hash_zero && cur.index_ones;
            res.kind     = tibp_pkg::KIND_SCRIPT_LEN;
            res.coinbase = cb;
            if (cb) begin
              if (var_value == 64'd0) begin
                nxt = start_field(cur, tibp_pkg::PH_SEQUENCE);
              end else begin
                nxt     = start_field(cur, tibp_pkg::PH_COINBASE);
                nxt.acc = var_value;
              end
            end else begin
              nxt           = start_field(cur, tibp_pkg::PH_OPCODE);
              nxt.push_num  = 1'b0;
              nxt.push_left = 7'd0;
            end
          end
        end
      end

      // Previous-hash bytes
      tibp_pkg::PH_HASH: begin
        res_valid   = 1'b1;
        res.kind    = tibp_pkg::KIND_HASH;
        res.value   = wide_byte;
        res.pos     = cur.counter[7:0];
        nxt.counter = cur.counter + 64'd1;
        if (data_byte != 8'd0) begin
          nxt.hash_zero = 1'b0;
        end
        if (cur.counter + 64'd1 >= 64'(tibp_pkg::HASH_BYTES)) begin
          nxt = start_field(nxt, tibp_pkg::PH_INDEX);
        end
      end

      // Coinbase script bytes, counted against the declared length
      tibp_pkg::PH_COINBASE: begin
        res_valid   = 1'b1;
        res.kind    = tibp_pkg::KIND_COINBASE;
        res.value   = wide_byte;
        res.pos     = cur.counter[7:0];
        nxt.counter = cur.counter + 64'd1;
        if (cur.counter + 64'd1 >= cur.acc) begin
          nxt = start_field(nxt, tibp_pkg::PH_SEQUENCE);
        end
      end

      // Push opcode: take a length or skip the slot
      tibp_pkg::PH_OPCODE: begin
        if (data_byte >= tibp_pkg::PUSH_MIN && data_byte <= tibp_pkg::PUSH_MAX) begin
          nxt.push_left = data_byte[6:0];
          nxt.counter   = 64'd0;
          nxt.phase     = tibp_pkg::PH_PUSH;
        end else begin
          nxt = end_push(cur);
        end
      end

      // Push data bytes
      tibp_pkg::PH_PUSH: begin
        res_valid   = 1'b1;
        res.kind    = cur.push_num ? tibp_pkg::KIND_PUBKEY : tibp_pkg::KIND_SIGNATURE;
        res.value   = wide_byte;
        res.pos     = cur.counter[7:0];
        nxt.counter = cur.counter + 64'd1;
        if (cur.push_left != 7'd0) begin
          left_dec = cur.push_left - 7'd1;
        end
        nxt.push_left = left_dec;
        if (left_dec == 7'd0) begin
          nxt = end_push(nxt);
        end
      end

      default: begin
        nxt = tibp_pkg::STATE_RESET;
      end
    endcase
  end

endmodule

/* tb/transaction_input_byte_parser_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transaction_input_byte_parser_core_tb
// Streams serialized transactions into the parser a byte at a time: mostly
// well-formed ones with random content (coinbase and regular inputs, every
// varint form, push and non-push opcodes), plus cut-off transactions, restarts
// and noise. A field tracker decodes the same bytes and checks every result.
// ----------------------------------------------------------------------------
module transaction_input_byte_parser_core_tb;

  localparam logic [7:0] VARINT_64 = 8'hFF;

  // Decodes the byte stream in step with the parser and holds the fields due
  class tx_field_tracker;
    logic [3:0]          phase;
    logic [63:0]         counter;
    logic [63:0]         acc;
    logic [3:0]          varint_left;
    bit                  hash_zero;
    logic [31:0]         prev_index;
    logic [6:0]          push_left;
    bit                  push_num;
    tibp_pkg::result_t   fields_due[$];
    int                  mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase = tibp_pkg::PH_VERSION;
      counter = '0;
      acc = '0;
      varint_left = '0;
      hash_zero = 1'b1;
      prev_index = '0;
      push_left = '0;
      push_num = 1'b0;
    endfunction

    function void start_field(logic [3:0] next);
      phase = next;
      counter = '0;
      acc = '0;
      varint_left = '0;
    endfunction

    function void end_push_slot();
      push_left = '0;
      if (!push_num) begin
        push_num = 1'b1;
        start_field(tibp_pkg::PH_OPCODE);
      end else begin
        start_field(tibp_pkg::PH_SEQUENCE);
      end
    endfunction

    // Fold a byte into a 4-byte little-endian word; true when complete
    function bit take_word(logic [7:0] b);
      acc |= 64'(b) << (8 * counter[1:0]);
      counter++;
      return counter >= 4;
    endfunction

    // Fold a byte into a varint; true when the value is complete
    function bit take_varint(logic [7:0] b);
      if (varint_left == 0) begin
        acc = 64'(b);
        counter = '0;
        if (b < tibp_pkg::VARINT_16) return 1'b1;
        acc = '0;
        varint_left = (b == tibp_pkg::VARINT_16) ? 4'd2 :
                      (b == tibp_pkg::VARINT_32) ? 4'd4 : 4'd8;
        return 1'b0;
      end
      acc |= 64'(b) << (8 * counter[2:0]);
      counter++;
      varint_left--;
      return varint_left == 0;
    endfunction

    function void add(logic [3:0] k, logic [63:0] v, logic [7:0] p, bit cb, bit l);
      fields_due.push_back(tibp_pkg::result_t'{kind: k, value: v, pos: p,
                                               coinbase: cb, last: l});
    endfunction

    // Note one accepted byte and queue the field it completes, if any
    function void note_byte(logic [7:0] b, logic rs);
      logic [63:0] v;
      logic [63:0] p;
      bit          cb;
      if (rs || phase > tibp_pkg::PH_SEQUENCE) clear();
      case (phase)
        tibp_pkg::PH_VERSION: begin
          if (take_word(b)) begin
            v = acc;
            start_field(tibp_pkg::PH_COUNT);
            add(tibp_pkg::KIND_VERSION, v, '0, 1'b0, 1'b0);
          end
        end
        tibp_pkg::PH_COUNT: begin
          if (take_varint(b)) begin
            v = acc;
            start_field(tibp_pkg::PH_HASH);
            hash_zero = 1'b1;
            add(tibp_pkg::KIND_COUNT, v, '0, 1'b0, 1'b0);
          end
        end
        tibp_pkg::PH_HASH: begin
          p = counter;
          if (b != 0) hash_zero = 1'b0;
          counter++;
          if (counter >= tibp_pkg::HASH_BYTES) start_field(tibp_pkg::PH_INDEX);
          add(tibp_pkg::KIND_HASH, 64'(b), p[7:0], 1'b0, 1'b0);
        end
        tibp_pkg::PH_INDEX: begin
          if (take_word(b)) begin
            prev_index = acc[31:0];
            v = acc;
            start_field(tibp_pkg::PH_SCRIPT_LEN);
            add(tibp_pkg::KIND_INDEX, v, '0, 1'b0, 1'b0);
          end
        end
        tibp_pkg::PH_SCRIPT_LEN: begin
          if (take_varint(b)) begin
            v = acc;
            cb = hash_zero && prev_index == tibp_pkg::COINBASE_INDEX;
            if (cb) begin
              if (v == 0) begin
                start_field(tibp_pkg::PH_SEQUENCE);
              end else begin
                start_field(tibp_pkg::PH_COINBASE);
                acc = v;
              end
            end else begin
              push_num = 1'b0;
              push_left = '0;
              start_field(tibp_pkg::PH_OPCODE);
            end
            add(tibp_pkg::KIND_SCRIPT_LEN, v, '0, cb, 1'b0);
          end
        end
        tibp_pkg::PH_COINBASE: begin
          p = counter;
          counter++;
          if (counter >= acc) start_field(tibp_pkg::PH_SEQUENCE);
          add(tibp_pkg::KIND_COINBASE, 64'(b), p[7:0], 1'b0, 1'b0);
        end
        tibp_pkg::PH_OPCODE: begin
          if (b >= tibp_pkg::PUSH_MIN && b <= tibp_pkg::PUSH_MAX) begin
            push_left = b[6:0];
            counter = '0;
            phase = tibp_pkg::PH_PUSH;
          end else begin
            end_push_slot();
          end
        end
        tibp_pkg::PH_PUSH: begin
          p = counter;
          counter++;
          if (push_left > 0) push_left--;
          add(push_num ? tibp_pkg::KIND_PUBKEY : tibp_pkg::KIND_SIGNATURE,
              64'(b), p[7:0], 1'b0, 1'b0);
          if (push_left == 0) end_push_slot();
        end
        default: begin
          if (take_word(b)) begin
            v = acc;
            clear();
            add(tibp_pkg::KIND_SEQUENCE, v, '0, 1'b0, 1'b1);
          end
        end
      endcase
    endfunction

    // Compare an accepted field with the oldest one due
    function void check_field(tibp_pkg::result_t got);
      tibp_pkg::result_t want;
      if (fields_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected field kind %0d value %h pos %0d cb %0b last %0b",
                   $realtime, got.kind, got.value, got.pos, got.coinbase, got.last);
        return;
      end
      want = fields_due.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.pos !== want.pos ||
          got.coinbase !== want.coinbase || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: field mismatch: expected kind %0d value %h pos %0d cb %0b ",
                    "last %0b, got kind %0d value %h pos %0d cb %0b last %0b"},
                   $realtime, want.kind, want.value, want.pos, want.coinbase, want.last,
                   got.kind, got.value, got.pos, got.coinbase, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  tibp_byte_if  byte_ch ();
  tibp_field_if field_ch ();

  transaction_input_byte_parser_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .field_ch (field_ch)
  );

  tx_field_tracker tracker;
  logic [7:0]      tx_bytes[$];
  int              src_idle_pct = 6;
  int              sink_idle_pct = 68;
  int              bytes_sent = 0;
  bit              need_restart = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Accept fields with random stalls and check each one
  initial begin
    field_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && field_ch.valid && field_ch.ready)
        tracker.check_field(tibp_pkg::result_t'{kind: field_ch.field_kind,
                                                value: field_ch.field_value,
                                                pos: field_ch.byte_position,
                                                coinbase: field_ch.is_coinbase,
                                                last: field_ch.last_of_transaction});
      field_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one byte, idling at random first, and note it once accepted
  task automatic send_byte(logic [7:0] b, logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.restart <= rs;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.note_byte(b, rs);
    bytes_sent++;
  endtask

  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) tx_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Encode a varint: 0 single byte, 1/2/3 for the 2/4/8-byte forms
  function automatic void put_varint(logic [63:0] v, int form);
    case (form)
      0: tx_bytes.push_back(v[7:0]);
      1: begin
        tx_bytes.push_back(tibp_pkg::VARINT_16);
        put_le(v, 2);
      end
      2: begin
        tx_bytes.push_back(tibp_pkg::VARINT_32);
        put_le(v, 4);
      end
      default: begin
        tx_bytes.push_back(VARINT_64);
        put_le(v, 8);
      end
    endcase
  endfunction

  // Build one transaction input with random content into tx_bytes
  function automatic void build_tx(bit coinbase, logic [63:0] script_len, int len_form,
                                   logic [7:0] op_a, logic [7:0] op_b);
    int          hash_mode;
    int          odd_pos;
    int          count_form;
    int          fill;
    logic [63:0] count;
    logic [31:0] index;
    logic [7:0]  ops[2];
    tx_bytes.delete();
    put_le({$urandom, $urandom}, 4);
    count_form = $urandom_range(3);
    count = (count_form == 0) ? 64'($urandom_range(0, 252)) : {$urandom, $urandom};
    put_varint(count, count_form);
    // hash modes: zero, random, one nonzero byte, zero with a plain index
    hash_mode = coinbase ? 0 : $urandom_range(1, 3);
    odd_pos = $urandom_range(0, tibp_pkg::HASH_BYTES - 1);
    for (int i = 0; i < tibp_pkg::HASH_BYTES; i++) begin
      if (hash_mode == 1) tx_bytes.push_back(8'($urandom));
      else if (hash_mode == 2 && i == odd_pos) tx_bytes.push_back(8'($urandom_range(1, 255)));
      else tx_bytes.push_back(8'h00);
    end
    case (hash_mode)
      0, 2: index = tibp_pkg::COINBASE_INDEX;
      1: index = $urandom_range(1) ? tibp_pkg::COINBASE_INDEX : $urandom;
      default: index = $urandom_range(1) ? 32'h0 : ($urandom & 32'hFFFF_FFFE);
    endcase
    put_le(64'(index), 4);
    put_varint(script_len, len_form);
    if (coinbase) begin
      // a huge declared length is only started; a restart must follow
      fill = (script_len > 512) ? 16 : int'(script_len);
      repeat (fill) tx_bytes.push_back(8'($urandom));
    end else begin
      ops[0] = op_a;
      ops[1] = op_b;
      foreach (ops[k]) begin
        tx_bytes.push_back(ops[k]);
        if (ops[k] >= tibp_pkg::PUSH_MIN && ops[k] <= tibp_pkg::PUSH_MAX)
          repeat (ops[k]) tx_bytes.push_back(8'($urandom));
      end
    end
    put_le(64'($urandom), 4);
  endfunction

  task automatic send_tx(bit restart_first, int cut);
    for (int i = 0; i < cut; i++) send_byte(tx_bytes[i], restart_first && i == 0);
  endtask

  // Mostly short pushes, a few full-size ones and some non-push opcodes
  function automatic logic [7:0] random_opcode();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) return 8'($urandom_range(1, 8));
    if (pick < 80) return $urandom_range(1) ? tibp_pkg::PUSH_MAX : 8'($urandom_range(9, 75));
    if (pick < 88) return 8'h00;
    return 8'($urandom_range(76, 255));
  endfunction

  task automatic send_random_tx();
    bit          cb;
    int          pick;
    int          form;
    int          cut;
    logic [63:0] slen;
    // occasional noise, after which a restart resynchronizes the parser
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom), 1'($urandom_range(1)));
      need_restart = 1'b1;
    end
    cb = ($urandom_range(99) < 40);
    if (cb) begin
      pick = $urandom_range(99);
      slen = (pick < 10) ? 64'd0 : (pick < 97) ? 64'($urandom_range(1, 24))
                                                : 64'($urandom_range(25, 80));
      form = $urandom_range(3);
    end else begin
      form = $urandom_range(3);
      slen = (form == 0) ? 64'($urandom_range(0, 252)) : {$urandom, $urandom};
    end
    build_tx(cb, slen, form, random_opcode(), random_opcode());
    cut = ($urandom_range(99) < 10) ? $urandom_range(1, tx_bytes.size() - 1)
                                    : tx_bytes.size();
    send_tx(need_restart || $urandom_range(3) == 0, cut);
    need_restart = (cut < tx_bytes.size());
  endtask

  initial begin
    int goal;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.restart = 1'b0;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty coinbase script, then a short one with a 2-byte length
    build_tx(1'b1, 64'd0, 0, 8'h00, 8'h00);
    send_tx(1'b1, tx_bytes.size());
    build_tx(1'b1, 64'd3, 1, 8'h00, 8'h00);
    send_tx(1'b0, tx_bytes.size());
    // push opcodes at both ends of the range, ignored 8-byte length
    build_tx(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 3, tibp_pkg::PUSH_MIN, tibp_pkg::PUSH_MAX);
    send_tx(1'b0, tx_bytes.size());
    // both slots non-push, then a non-push followed by a push
    build_tx(1'b0, 64'd5, 0, 8'h00, 8'h4C);
    send_tx(1'b0, tx_bytes.size());
    build_tx(1'b0, 64'h1234, 2, 8'hFF, 8'h02);
    send_tx(1'b0, tx_bytes.size());
    // coinbase longer than 255 bytes wraps the byte position
    build_tx(1'b1, 64'd258, 1, 8'h00, 8'h00);
    send_tx(1'b0, tx_bytes.size());
    // huge coinbase length, broken off by a restart
    build_tx(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 3, 8'h00, 8'h00);
    send_tx(1'b0, tx_bytes.size());
    // restart in the middle of a version
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    build_tx(1'b0, 64'd0, 0, 8'h01, 8'h01);
    send_tx(1'b1, tx_bytes.size());

    // three idling profiles: sender light, receiver light, none
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 6 : (p == 1) ? 68 : 0;
      sink_idle_pct = (p == 0) ? 68 : (p == 1) ? 6 : 0;
      goal = bytes_sent + 240;
      while (bytes_sent < goal) send_random_tx();
    end
    byte_ch.valid <= 1'b0;

    // drain the fields still due, then let the clock run idle before the verdict
    while (tracker.fields_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
